// ----- rtl/fau_pkg.sv -----
package fau_pkg;

    localparam int DATA_W = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_INVALID = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] value;
    } t_sat_res;

    // Apply sign to a magnitude and clamp to the signed 32-bit range.
    function automatic t_sat_res sat_mag(input logic neg, input logic [63:0] mag);
        t_sat_res   r;
        logic [63:0] tmp;
        tmp = 64'd0 - mag;
        if (neg) begin
            r.sat   = (mag > 64'h0000_0000_8000_0000);
            r.value = r.sat ? Q_MIN : tmp[DATA_W-1:0];
        end else begin
            r.sat   = (mag > 64'h0000_0000_7FFF_FFFF);
            r.value = r.sat ? Q_MAX : mag[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/fau_req_if.sv -----
interface fau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

// ----- rtl/fau_rsp_if.sv -----
interface fau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [1:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ----- rtl/five_op_arithmetic_unit_core.sv -----
// An accepted request is decoded in S_DEC; add, subtract, invalid opcode, divide by zero and
// power with exponent <= 0 go straight to S_FIN; multiply waits in S_MULC for the product;
// divide waits in S_DIV (one quotient bit per cycle in the restoring divider); power runs
// S_POWI then S_POWC once per multiply. One request at a time: the sequencer returns to idle
// as the result is handed to the output register, which holds it while the consumer stalls.
// Reset (i_rst_n low, synchronous) idles the sequencer and divider and drops any pending result.
module five_op_arithmetic_unit_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fau_req_if.sink   i_req,
    fau_rsp_if.source o_rsp
);
    import fau_pkg::*;

    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int CNT_W = 33 - FRAC_BITS;
    localparam logic [31:0] Q_ONE     = 32'd1 << FRAC_BITS;
    localparam logic [31:0] Q_NEG_ONE = ~Q_ONE + 32'd1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_MULC = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_POWI = 7'b0010000,
        S_POWC = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [31:0]      r_a, n_a;
    logic [31:0]      r_b, n_b;
    logic [31:0]      r_acc, n_acc;
    logic [CNT_W-1:0] r_rem_cnt, n_rem_cnt;
    logic             r_cnt_odd, n_cnt_odd;
    logic [31:0]      r_res, n_res;
    t_status          r_st, n_st;
    logic             r_out_vld, n_out_vld;
    logic [31:0]      r_out_res, n_out_res;
    t_status          r_out_st, n_out_st;

    logic             a_neg, b_neg;
    logic [31:0]      a_mag, b_mag, acc_mag;
    logic [31:0]      mul_x, mul_y;
    logic [63:0]      prod;
    logic [63:0]      prod_shr;
    logic [32:0]      sum;
    logic             sum_ovf;
    logic [32:0]      pow_cnt_full;
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_quot;
    t_sat_res         mul_sat, div_sat, pow_sat;
    logic             out_free;

    // Sign and magnitude of the latched operands and the power accumulator.
    assign a_neg   = r_a[31];
    assign b_neg   = r_b[31];
    assign a_mag   = a_neg ? (32'd0 - r_a) : r_a;
    assign b_mag   = b_neg ? (32'd0 - r_b) : r_b;
    assign acc_mag = r_acc[31] ? (32'd0 - r_acc) : r_acc;

    // The one multiplier serves both multiply (a*b) and each power step (acc*base).
    assign mul_x = (r_state == S_POWI) ? acc_mag : a_mag;
    assign mul_y = (r_state == S_POWI) ? a_mag : b_mag;

    fau_mul u_mul (
        .i_clk  (i_clk),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_prod (prod)
    );

    fau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (a_mag),
        .i_divisor  (b_mag),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Truncate the product toward zero by dropping fraction bits of the magnitude.
    assign prod_shr = prod >> FRAC_BITS;
    assign mul_sat  = sat_mag(a_neg ^ b_neg, prod_shr);
    assign pow_sat  = sat_mag(r_acc[31] ^ a_neg, prod_shr);
    assign div_sat  = sat_mag(a_neg ^ b_neg, {{(64-DVD_W){1'b0}}, div_quot});

    // Add and subtract in 33 bits; overflow when the top two bits disagree.
    assign sum     = (r_op == OP_SUB) ? ({r_a[31], r_a} - {r_b[31], r_b})
                                      : ({r_a[31], r_a} + {r_b[31], r_b});
    assign sum_ovf = sum[32] ^ sum[31];

    // Multiply count for power: ceil(exponent) in whole units.
    assign pow_cnt_full = {1'b0, r_b} + {1'b0, Q_ONE} - 33'd1;

    assign out_free = !r_out_vld || o_rsp.ready;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_acc     = r_acc;
        n_rem_cnt = r_rem_cnt;
        n_cnt_odd = r_cnt_odd;
        n_res     = r_res;
        n_st      = r_st;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // Latch a new transaction.
                if (i_req.valid) begin
                    n_op    = i_req.opcode;
                    n_a     = i_req.operand_a;
                    n_b     = i_req.operand_b;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res   = 32'd0;
                n_st    = ST_OK;
                n_state = S_FIN;
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        if (sum_ovf) begin
                            n_res = sum[32] ? Q_MIN : Q_MAX;
                            n_st  = ST_SAT;
                        end else begin
                            n_res = sum[31:0];
                        end
                    end
                    OP_MUL: begin
                        // Multiplier is loaded this cycle; product is ready next.
                        n_state = S_MULC;
                    end
                    OP_DIV: begin
                        if (r_b == 32'd0) begin
                            n_st = ST_DIV0;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    OP_POW: begin
                        if (b_neg || (r_b == 32'd0)) begin
                            n_res = Q_ONE;
                        end else begin
                            n_acc     = Q_ONE;
                            n_rem_cnt = pow_cnt_full[32:FRAC_BITS];
                            n_cnt_odd = pow_cnt_full[FRAC_BITS];
                            n_state   = S_POWI;
                        end
                    end
                    default: begin
                        n_st = ST_INVALID;
                    end
                endcase
            end
            S_MULC: begin
                n_res   = mul_sat.value;
                n_st    = mul_sat.sat ? ST_SAT : ST_OK;
                n_state = S_FIN;
            end
            S_DIV: begin
                // Hold until the divider has produced every quotient bit.
                if (div_done) begin
                    n_res   = div_sat.value;
                    n_st    = div_sat.sat ? ST_SAT : ST_OK;
                    n_state = S_FIN;
                end
            end
            S_POWI: begin
                n_state = S_POWC;
            end
            S_POWC: begin
                priority if (pow_sat.sat) begin
                    // Saturate on the side given by the sign of the full power.
                    n_res   = (a_neg && r_cnt_odd) ? Q_MIN : Q_MAX;
                    n_st    = ST_SAT;
                    n_state = S_FIN;
                end else if (pow_sat.value == r_acc) begin
                    // Fixed point reached: further multiplies change nothing.
                    n_res   = r_acc;
                    n_state = S_FIN;
                end else if (pow_sat.value == 32'd0) begin
                    n_res   = 32'd0;
                    n_state = S_FIN;
                end else if (r_a == Q_NEG_ONE) begin
                    // Base of minus one only flips sign; finish by parity of what is left.
                    n_res   = r_rem_cnt[0] ? pow_sat.value : (32'd0 - pow_sat.value);
                    n_state = S_FIN;
                end else if (r_rem_cnt == CNT_W'(1)) begin
                    n_res   = pow_sat.value;
                    n_state = S_FIN;
                end else begin
                    n_acc     = pow_sat.value;
                    n_rem_cnt = r_rem_cnt - CNT_W'(1);
                    n_state   = S_POWI;
                end
            end
            S_FIN: begin
                // Hand off once the output register is free.
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        n_out_res = r_out_res;
        n_out_st  = r_out_st;
        if ((r_state == S_FIN) && out_free) begin
            n_out_vld = 1'b1;
            n_out_res = r_res;
            n_out_st  = r_st;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_op      <= n_op;
        r_a       <= n_a;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_rem_cnt <= n_rem_cnt;
        r_cnt_odd <= n_cnt_odd;
        r_res     <= n_res;
        r_st      <= n_st;
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.result_value = r_out_res;
    assign o_rsp.status       = r_out_st;
endmodule

// ----- rtl/fau_mul.sv -----
module fau_mul (
    input  logic        i_clk,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    // Unsigned magnitude product, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_x) * 64'(i_y);
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/fau_div.sv -----
module fau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_dividend,
    input  logic [31:0]           i_divisor,
    output logic                  o_done,
    output logic [31+FRAC_BITS:0] o_quot
);
    localparam int DVD_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      r_dvs, n_dvs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             fits;

    // One restoring step per cycle; quotient bits shift in behind the dividend.
    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = {i_dividend, {FRAC_BITS{1'b0}}};
            n_rem  = 32'd0;
            n_dvs  = i_divisor;
            n_cnt  = CNT_W'(DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DVD_W-2:0], fits};
            n_rem = fits ? diff[31:0] : trial[31:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

// ----- rtl/fau_checker.sv -----
module fau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_result,
    input logic [1:0]  i_rsp_status
);
    import fau_pkg::*;

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_result) && $stable(i_rsp_status))
        else $error("result changed while stalled");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_DIV0 || i_rsp_status == ST_INVALID) |->
            i_rsp_result == 32'd0)
        else $error("error status with nonzero result");

    // Saturated results sit at one end of the range.
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_SAT) |->
            i_rsp_result == Q_MAX || i_rsp_result == Q_MIN)
        else $error("saturated result off the rails");

    // One transaction in flight: busy right after an accept.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after accept");
endmodule

bind five_op_arithmetic_unit_core fau_checker u_fau_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_result (o_rsp.result_value),
    .i_rsp_status (o_rsp.status)
);
